FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, a disable condition, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/aip_pkg.sv
package aip_pkg;

   // Configuration register indexes.
   localparam logic CSR_NUMBER_BASE   = 1'b0;
   localparam logic CSR_UNSIGNED_MODE = 1'b1;

   // Digit value that marks a character which is no digit in any base.
   localparam logic [5:0] NO_DIGIT = 6'h3F;

   // Largest legal radix.
   localparam logic [5:0] MAX_BASE = 6'd36;

   // Scan phases of the back end.
   typedef enum logic [2:0] {
      PH_WS,
      PH_ZERO,
      PH_AFTERX,
      PH_DIGITS,
      PH_DONE,
      PH_BAD,
      PH_FIRST
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_DIGITS,
      ST_CLAMPED,
      ST_BAD_BASE
   } status_type;

   // Input word.
   typedef struct packed {
      logic [7:0] char_code;
      logic       string_end;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [31:0] parsed_value;
      logic [12:0] stop_position;
      status_type  status;
   } rsp_word_type;

   // Classified character, as queued between front and back.
   typedef struct packed {
      logic [5:0] digit_val;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_zero;
      logic       is_x;
      logic       last;
   } char_class_type;

   // Scan summary handed from the scanner to the result stage.
   typedef struct packed {
      logic [31:0] acc;
      logic [12:0] stop;
      logic        overflow;
      logic        negative;
      logic        digit_seen;
      logic        bad_base;
      logic        unsigned_mode;
   } final_type;

endpackage

FILE: rtl/aip_front.sv
module aip_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  aip_pkg::req_word_type   req_word,
   output logic                    q_valid,
   output aip_pkg::char_class_type q_word,
   input  logic                    q_pop
);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_SPACE = 8'h20;

   aip_pkg::char_class_type cls;
   aip_pkg::char_class_type q_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    push;
   logic [7:0]              c;

   // Classify the incoming character.
   always_comb begin
      c = req_word.char_code;
      cls = '0;
      if (c inside {[8'h30:8'h39]}) begin
         cls.digit_val = 6'(c - 8'd48);
      end else if (c inside {[8'h61:8'h7A]}) begin
         cls.digit_val = 6'(c - 8'd87);
      end else if (c inside {[8'h41:8'h5A]}) begin
         cls.digit_val = 6'(c - 8'd55);
      end else begin
         cls.digit_val = aip_pkg::NO_DIGIT;
      end
      cls.is_space = (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
      cls.is_minus = (c == CH_MINUS);
      cls.is_plus  = (c == CH_PLUS);
      cls.is_zero  = (c == CH_ZERO);
      cls.is_x     = (c == CH_LOW_X) || (c == CH_UP_X);
      cls.last     = req_word.string_end;
   end

   // Two-entry queue toward the scanner.
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_word    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/aip_back.sv
module aip_back #(
   parameter int MAX_STRING_LEN = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  aip_pkg::char_class_type q_word,
   output logic                    q_pop,
   input  logic [5:0]              number_base,
   input  logic                    unsigned_mode,
   input  logic                    fin_ready,
   output logic                    fin_valid,
   output aip_pkg::final_type      fin_word
);

   localparam int IDX_W = $clog2(MAX_STRING_LEN + 1);

   aip_pkg::phase_type phase_ff, phase_in, phase_eff, phase_n;
   logic [31:0]        acc_ff, acc_in, acc_n;
   logic [5:0]         base_ff, base_in, base_eff, base_n;
   logic               neg_ff, neg_in, neg_n;
   logic               dig_ff, dig_in, dig_n;
   logic               ovf_ff, ovf_in, ovf_n;
   logic [IDX_W-1:0]   idx_ff, idx_in, idx_n;
   logic [IDX_W-1:0]   stop_ff, stop_in, stop_n, stop_last;
   logic               first;
   logic               first_path;
   logic               want_digit;
   logic [37:0]        mult;
   logic [37:0]        sum;

   // A last word waits until the result stage has room.
   assign q_pop     = q_valid && (!q_word.last || fin_ready);
   assign fin_valid = q_pop && q_word.last;

   // The radix is sampled at the first character of a string.
   assign first     = (idx_ff == '0);
   assign base_eff  = first ? number_base : base_ff;
   assign phase_eff = (first && ((number_base == 6'd1) || (number_base > aip_pkg::MAX_BASE)))
                      ? aip_pkg::PH_BAD : phase_ff;

   // One multiply-add per digit.
   assign mult = acc_ff * base_n;
   assign sum  = mult + 38'(q_word.digit_val);

   // Scan step for the word at the head of the queue.
   always_comb begin
      phase_n    = phase_eff;
      base_n     = base_eff;
      acc_n      = acc_ff;
      neg_n      = neg_ff;
      dig_n      = dig_ff;
      ovf_n      = ovf_ff;
      stop_n     = stop_ff;
      first_path = 1'b0;
      want_digit = 1'b0;

      case (phase_eff)
         aip_pkg::PH_WS: begin
            if (q_word.is_space) begin
               phase_n = aip_pkg::PH_WS;
            end else if (q_word.is_minus) begin
               neg_n   = 1'b1;
               phase_n = aip_pkg::PH_FIRST;
            end else if (q_word.is_plus) begin
               phase_n = aip_pkg::PH_FIRST;
            end else begin
               first_path = 1'b1;
            end
         end
         aip_pkg::PH_FIRST: begin
            first_path = 1'b1;
         end
         aip_pkg::PH_ZERO: begin
            if (q_word.is_x) begin
               base_n  = 6'd16;
               phase_n = aip_pkg::PH_AFTERX;
            end else begin
               if (base_eff == 6'd0) begin
                  base_n = 6'd8;
               end
               dig_n      = 1'b1;
               want_digit = 1'b1;
            end
         end
         aip_pkg::PH_AFTERX, aip_pkg::PH_DIGITS: begin
            want_digit = 1'b1;
         end
         default: begin
            phase_n = phase_eff;
         end
      endcase

      // First significant character: a zero may open a prefix.
      if (first_path) begin
         if (q_word.is_zero && ((base_eff == 6'd0) || (base_eff == 6'd16))) begin
            phase_n = aip_pkg::PH_ZERO;
         end else begin
            if (base_eff == 6'd0) begin
               base_n = 6'd10;
            end
            want_digit = 1'b1;
         end
      end

      // Accumulate a digit, or stop on a character that is none.
      if (want_digit) begin
         if ((base_n < 6'd2) || (q_word.digit_val >= base_n)) begin
            stop_n  = idx_ff;
            phase_n = aip_pkg::PH_DONE;
         end else begin
            dig_n = 1'b1;
            if (sum[37:32] == 6'd0) begin
               acc_n = sum[31:0];
            end else begin
               ovf_n = 1'b1;
            end
            phase_n = aip_pkg::PH_DIGITS;
         end
      end

      idx_n = (idx_ff < IDX_W'(MAX_STRING_LEN)) ? idx_ff + IDX_W'(1) : idx_ff;
   end

   // Summary for the result stage on the last word.
   always_comb begin
      stop_last = ((phase_n != aip_pkg::PH_DONE) && (phase_n != aip_pkg::PH_BAD))
                  ? idx_n : stop_n;
      fin_word.acc           = acc_n;
      fin_word.stop          = 13'(stop_last);
      fin_word.overflow      = ovf_n;
      fin_word.negative      = neg_n;
      fin_word.digit_seen    = dig_n || (phase_n == aip_pkg::PH_ZERO);
      fin_word.bad_base      = (phase_n == aip_pkg::PH_BAD);
      fin_word.unsigned_mode = unsigned_mode;
   end

   // Next state: advance on a pop, clear after the last word.
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      dig_in   = dig_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      if (q_pop) begin
         if (q_word.last) begin
            phase_in = aip_pkg::PH_WS;
            acc_in   = '0;
            base_in  = '0;
            neg_in   = 1'b0;
            dig_in   = 1'b0;
            ovf_in   = 1'b0;
            idx_in   = '0;
            stop_in  = '0;
         end else begin
            phase_in = phase_n;
            acc_in   = acc_n;
            base_in  = base_n;
            neg_in   = neg_n;
            dig_in   = dig_n;
            ovf_in   = ovf_n;
            idx_in   = idx_n;
            stop_in  = stop_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= aip_pkg::PH_WS;
         acc_ff   <= '0;
         base_ff  <= '0;
         neg_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         dig_ff   <= dig_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

FILE: rtl/aip_final.sv
module aip_final (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fin_valid,
   input  aip_pkg::final_type    fin_word,
   output logic                  fin_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output aip_pkg::rsp_word_type rsp_word
);

   aip_pkg::final_type    hold_ff;
   logic                  hold_valid_ff, hold_valid_in;
   aip_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  move;

   // The held summary moves on when the output register is free.
   assign move      = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign fin_ready = !hold_valid_ff || move;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Clamp, negate and pick the status.
   always_comb begin
      rsp_in.parsed_value  = 32'd0;
      rsp_in.stop_position = 13'd0;
      rsp_in.status        = aip_pkg::ST_OK;
      if (hold_ff.bad_base) begin
         rsp_in.status = aip_pkg::ST_BAD_BASE;
      end else if (!hold_ff.digit_seen) begin
         rsp_in.status = aip_pkg::ST_NO_DIGITS;
      end else begin
         rsp_in.stop_position = hold_ff.stop;
         rsp_in.parsed_value  = hold_ff.acc;
         if (hold_ff.unsigned_mode) begin
            if (hold_ff.overflow) begin
               rsp_in.parsed_value = 32'hFFFF_FFFF;
               rsp_in.status       = aip_pkg::ST_CLAMPED;
            end else if (hold_ff.negative) begin
               rsp_in.parsed_value = 32'd0 - hold_ff.acc;
            end
         end else if (hold_ff.negative) begin
            if (hold_ff.overflow || (hold_ff.acc > 32'h8000_0000)) begin
               rsp_in.parsed_value = 32'h8000_0000;
               rsp_in.status       = aip_pkg::ST_CLAMPED;
            end else begin
               rsp_in.parsed_value = 32'd0 - hold_ff.acc;
            end
         end else if (hold_ff.overflow || (hold_ff.acc > 32'h7FFF_FFFF)) begin
            rsp_in.parsed_value = 32'h7FFF_FFFF;
            rsp_in.status       = aip_pkg::ST_CLAMPED;
         end
      end
   end

   always_comb begin
      hold_valid_in = fin_valid ? 1'b1 : (move ? 1'b0 : hold_valid_ff);
      rsp_valid_in  = move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid) begin
         hold_ff <= fin_word;
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/ascii_integer_parser.sv
// Streaming string-to-integer converter in the manner of strtol and strtoul with a 32-bit
// long. One character word enters per cycle while the character queue has room and the
// result stage takes each last word, and one result word leaves for each word marked
// string_end; that rate is set by the scanner, which performs one 32-by-6 multiply-add
// and overflow check per character. After its last character is accepted, a result
// passes through the two-entry character queue, whose head the scanner works on, the held
// scan summary, on which the clamp stage works, and the output register.
// The radix register is sampled at the first character of each string and the unsigned
// register at its last; the user must write both only while the block is idle, which the
// block itself does not enforce. Positions saturate at MAX_STRING_LEN.
module ascii_integer_parser #(
   parameter int MAX_STRING_LEN = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  aip_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output aip_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [5:0]            csr_wdata
);

   logic [5:0]              number_base_ff;
   logic                    unsigned_mode_ff;
   logic                    q_valid;
   logic                    q_pop;
   aip_pkg::char_class_type q_word;
   logic                    fin_valid;
   logic                    fin_ready;
   aip_pkg::final_type      fin_word;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff   <= 6'd10;
         unsigned_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            aip_pkg::CSR_NUMBER_BASE:   number_base_ff   <= csr_wdata;
            aip_pkg::CSR_UNSIGNED_MODE: unsigned_mode_ff <= csr_wdata[0];
            default:                    number_base_ff   <= number_base_ff;
         endcase
      end
   end

   aip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_valid   (q_valid),
      .q_word    (q_word),
      .q_pop     (q_pop)
   );

   aip_back #(
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_word        (q_word),
      .q_pop         (q_pop),
      .number_base   (number_base_ff),
      .unsigned_mode (unsigned_mode_ff),
      .fin_ready     (fin_ready),
      .fin_valid     (fin_valid),
      .fin_word      (fin_word)
   );

   aip_final u_final (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_word  (fin_word),
      .fin_ready (fin_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: rtl/aip_checker.sv
`include "assert_macros.svh"

module aip_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input aip_pkg::rsp_word_type rsp_word
);

   logic err_result;
   logic rsp_zero;
   logic clamped;
   logic clamp_limit;

   // Classify the shown result word.
   assign err_result  = (rsp_word.status == aip_pkg::ST_BAD_BASE) ||
                        (rsp_word.status == aip_pkg::ST_NO_DIGITS);
   assign rsp_zero    = (rsp_word.parsed_value == 32'd0) && (rsp_word.stop_position == 13'd0);
   assign clamped     = (rsp_word.status == aip_pkg::ST_CLAMPED);
   assign clamp_limit = (rsp_word.parsed_value == 32'hFFFF_FFFF) ||
                        (rsp_word.parsed_value == 32'h7FFF_FFFF) ||
                        (rsp_word.parsed_value == 32'h8000_0000);

   // A stalled result word holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // No result word is shown in the cycle after reset.
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // Error results carry a zero value and a zero position.
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && err_result, rsp_zero)

   // A clamped result is one of the three limits.
   `ASSERT_IMPLIES(a_clamp_value, clock, reset, rsp_valid && clamped, clamp_limit)

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

FILE: sim/ascii_integer_parser_tb.sv
module ascii_integer_parser_tb;
   import aip_pkg::*;

   localparam int MAX_LEN       = 4096;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int NOT_A_DIGIT   = 99;
   localparam int COMMON_RADIX [6] = '{0, 2, 8, 10, 16, 36};

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_we;
   logic         csr_index;
   logic [5:0]   csr_wdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int fail_count    = 0;
   int cycle_count   = 0;
   int items_sent    = 0;

   // Conversions predicted for accepted strings, oldest first.
   rsp_word_type pending_conversions [$];

   // Register values as last written.
   logic [5:0] radix_setting;
   logic       unsigned_setting;

   // Scanner state of the predictor.
   phase_type   parse_phase;
   logic [31:0] acc_value;
   logic [5:0]  work_base;
   logic        minus_seen;
   logic        any_digit;
   logic        overflowed;
   int          char_pos;
   int          stop_pos;

   ascii_integer_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The run is cut short as a failure once the cycle count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Conversion predictor
   // ---------------------------------------------------------------------------------

   function automatic int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "z") return int'(c - "a") + 10;
      if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
      return NOT_A_DIGIT;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void clear_scan();
      parse_phase = PH_WS;
      acc_value   = '0;
      work_base   = '0;
      minus_seen  = 1'b0;
      any_digit   = 1'b0;
      overflowed  = 1'b0;
      char_pos    = 0;
      stop_pos    = 0;
   endfunction

   // Accumulate one digit, or end the scan if the character is no digit of the base.
   function automatic void take_digit(logic [7:0] c, int pos);
      logic [31:0] d;
      logic [31:0] lim;
      logic [31:0] rem;
      d = digit_of(c);
      if (work_base < 2 || d >= work_base) begin
         stop_pos    = pos;
         parse_phase = PH_DONE;
         return;
      end
      any_digit = 1'b1;
      lim = 32'hFFFF_FFFF / work_base;
      rem = 32'hFFFF_FFFF % work_base;
      if (acc_value < lim || (acc_value == lim && d <= rem))
         acc_value = acc_value * work_base + d;
      else
         overflowed = 1'b1;
      parse_phase = PH_DIGITS;
   endfunction

   // A leading zero may open a prefix when the base is detected or hexadecimal.
   function automatic void take_first(logic [7:0] c, int pos);
      if (c == "0" && (work_base == 0 || work_base == 16)) begin
         parse_phase = PH_ZERO;
         return;
      end
      if (work_base == 0) work_base = 6'd10;
      take_digit(c, pos);
   endfunction

   // Advance the scan by one character; returns 1 with the result on the last one.
   function automatic bit convert_char(logic [7:0] c, bit last, output rsp_word_type res);
      int          pos;
      logic [31:0] val;
      pos = char_pos;
      res = '0;
      if (pos == 0) begin
         work_base = radix_setting;
         if (work_base == 1 || work_base > MAX_BASE) parse_phase = PH_BAD;
      end

      case (parse_phase)
         PH_WS: begin
            if (!is_blank(c)) begin
               if (c == "-") begin
                  minus_seen  = 1'b1;
                  parse_phase = PH_FIRST;
               end else if (c == "+") begin
                  parse_phase = PH_FIRST;
               end else begin
                  take_first(c, pos);
               end
            end
         end
         PH_FIRST: take_first(c, pos);
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               work_base   = 6'd16;
               parse_phase = PH_AFTERX;
            end else begin
               if (work_base == 0) work_base = 6'd8;
               any_digit = 1'b1;
               take_digit(c, pos);
            end
         end
         PH_AFTERX, PH_DIGITS: take_digit(c, pos);
         default: ;
      endcase

      if (char_pos < MAX_LEN) char_pos++;
      if (!last) return 1'b0;

      // A string that ends mid-scan stops just past its last character.
      if (parse_phase != PH_DONE && parse_phase != PH_BAD) begin
         if (parse_phase == PH_ZERO) any_digit = 1'b1;
         stop_pos = char_pos;
      end

      if (parse_phase == PH_BAD) begin
         res.status = ST_BAD_BASE;
      end else if (!any_digit) begin
         res.status = ST_NO_DIGITS;
      end else begin
         val = acc_value;
         res.status = ST_OK;
         res.stop_position = stop_pos[12:0];
         if (unsigned_setting) begin
            if (overflowed) begin
               val = 32'hFFFF_FFFF;
               res.status = ST_CLAMPED;
            end else if (minus_seen) begin
               val = -val;
            end
         end else if (minus_seen) begin
            if (overflowed || val > 32'h8000_0000) begin
               val = 32'h8000_0000;
               res.status = ST_CLAMPED;
            end else begin
               val = -val;
            end
         end else if (overflowed || val > 32'h7FFF_FFFF) begin
            val = 32'h7FFF_FFFF;
            res.status = ST_CLAMPED;
         end
         res.parsed_value = val;
      end
      clear_scan();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------------

   // Offer one character word, with a random gap ahead of it, and wait for acceptance.
   task automatic send_char(logic [7:0] c, bit last);
      rsp_word_type res;
      bit           has_result;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= '{char_code: c, string_end: last};
      do @(posedge clock); while (!req_ready);
      items_sent++;
      has_result = convert_char(c, last, res);
      if (has_result) pending_conversions.push_back(res);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Wait until every predicted conversion has come out and the pipeline has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written back to back while the block is idle.
   task automatic configure(logic [5:0] radix, logic uns);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_NUMBER_BASE;
      csr_wdata <= radix;
      @(posedge clock);
      csr_index <= CSR_UNSIGNED_MODE;
      csr_wdata <= {5'b0, uns};
      @(posedge clock);
      csr_we <= 1'b0;
      radix_setting    = radix;
      unsigned_setting = uns;
   endtask

   // The receiver stalls at random, or for a long stretch when a test asks for it.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_conversions.size() == 0) begin
            $error("unexpected result word: parsed_value %h", rsp_word.parsed_value);
            fail_count++;
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_word.parsed_value !== want.parsed_value) begin
               $error("parsed_value: expected %h, got %h",
                      want.parsed_value, rsp_word.parsed_value);
               fail_count++;
            end
            if (rsp_word.stop_position !== want.stop_position) begin
               $error("stop_position: expected %0d, got %0d",
                      want.stop_position, rsp_word.stop_position);
               fail_count++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Random strings
   // ---------------------------------------------------------------------------------

   function automatic logic [7:0] blank_char();
      int v;
      v = $urandom_range(5);
      return (v == 5) ? 8'h20 : 8'(9 + v);
   endfunction

   function automatic logic [7:0] digit_char(int v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
   endfunction

   // Common radixes and arbitrary legal ones in equal share, and now and then an illegal one.
   function automatic logic [5:0] pick_radix();
      int r;
      r = $urandom_range(9);
      if (r < 4) return 6'(COMMON_RADIX[$urandom_range(5)]);
      if (r < 8) return 6'($urandom_range(2, 36));
      return $urandom_range(1) ? 6'd1 : 6'($urandom_range(37, 63));
   endfunction

   // Most strings are well formed numbers with random content; the rest are noise.
   task automatic send_random_string();
      logic [7:0] text [$];
      string      alphabet = "0xX+- \t9azZ";
      int         radix;
      int         n;
      if ($urandom_range(99) < 80) begin
         repeat ($urandom_range(3)) text.push_back(blank_char());
         case ($urandom_range(2))
            1: text.push_back("-");
            2: text.push_back("+");
            default: ;
         endcase
         radix = radix_setting;
         if (radix == 0 || radix == 16) begin
            case ($urandom_range(3))
               0: begin
                  text.push_back("0");
                  text.push_back($urandom_range(1) ? "x" : "X");
                  radix = 16;
               end
               1: begin
                  text.push_back("0");
                  if (radix == 0) radix = 8;
               end
               default: if (radix == 0) radix = 10;
            endcase
         end
         if (radix < 2 || radix > 36) radix = 10;
         n = ($urandom_range(9) < 7) ? $urandom_range(10) : $urandom_range(11, 40);
         repeat (n) text.push_back(digit_char($urandom_range(radix - 1)));
         if ($urandom_range(1))
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(1)) text.push_back(8'($urandom_range(255)));
            else text.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
         end
      end
      if (text.size() == 0) text.push_back(8'($urandom_range(255)));
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Whitespace, both signs, a stop character and the extreme character codes.
   task automatic test_signs_and_blanks();
      configure(6'd10, 1'b0);
      send_text("\t+7z");
      send_text(" -12");
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
   endtask

   // Prefix detection: a bare hex prefix, a lone zero, octal, and hex with its prefix.
   task automatic test_base_detection();
      configure(6'd0, 1'b0);
      send_text("0x");
      send_text("0");
      send_text("017");
      configure(6'd16, 1'b1);
      send_text("-0XfF");
   endtask

   task automatic test_bad_base();
      configure(6'd1, 1'b0);
      send_text("5");
      configure(6'd63, 1'b0);
      send_text("1");
   endtask

   // The largest radix overflows and clamps unsigned; a signed binary string does not.
   task automatic test_clamping();
      configure(6'd36, 1'b1);
      send_text("-zzzzzzz");
      configure(6'd2, 1'b0);
      send_text("-1z");
   endtask

   task automatic test_random(int n, int send_pct, int recv_pct);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         configure(pick_radix(), 1'($urandom_range(1)));
         repeat (8) send_random_string();
      end
   endtask

   // One-word strings pile up behind a long receiver hold-off until the input stalls.
   task automatic test_input_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(6'd10, 1'b0);
      hold_requests++;
      repeat (60) send_char(digit_char($urandom_range(9)), 1'b1);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_NUMBER_BASE;
      csr_wdata = '0;
      radix_setting    = 6'd10;
      unsigned_setting = 1'b0;
      clear_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_signs_and_blanks();
      test_base_detection();
      test_bad_base();
      test_clamping();
      test_random(460, 17, 48);
      test_random(460, 48, 17);
      test_random(450, 0, 0);
      test_input_stall();
      drain();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
